// File: hdl/instruction_format_decoder_core_defines.svh
// assertion macros for the instruction format decoder
`ifndef INSTRUCTION_FORMAT_DECODER_CORE_DEFINES_SVH
`define INSTRUCTION_FORMAT_DECODER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ifd_pkg.sv
// types and constants for the instruction format decoder
package ifd_pkg;

    localparam int OFFSET_W = 24;
    localparam int HALF_W   = 16;
    localparam int ROM_W    = 25;
    localparam int OP_W     = 6;
    localparam int REG_W    = 5;
    localparam int COND_W   = 4;
    localparam int IMM_W    = 26;
    localparam int LEN_W    = 3;

    typedef enum logic [2:0] {
        FMT_I   = 3'd0,
        FMT_II  = 3'd1,
        FMT_III = 3'd2,
        FMT_IV  = 3'd3,
        FMT_V   = 3'd4,
        FMT_VI  = 3'd5,
        FMT_VII = 3'd6
    } t_format;

    localparam logic [OP_W-1:0]  OP_LONG_MIN    = 6'h28;
    localparam logic [OP_W-1:0]  OP_EXT         = 6'h3E;
    localparam logic [OP_W-1:0]  OP_UNDEF_A     = 6'h1B;
    localparam logic [OP_W-1:0]  OP_UNDEF_B     = 6'h32;
    localparam logic [OP_W-1:0]  OP_UNDEF_C     = 6'h36;
    localparam logic [OP_W-1:0]  OP_FMT_I_MIN   = 6'h00;
    localparam logic [OP_W-1:0]  OP_FMT_I_MAX   = 6'h0F;
    localparam logic [OP_W-1:0]  OP_FMT_II_MIN  = 6'h10;
    localparam logic [OP_W-1:0]  OP_FMT_II_MAX  = 6'h1F;
    localparam logic [OP_W-1:0]  OP_FMT_III_MIN = 6'h20;
    localparam logic [OP_W-1:0]  OP_FMT_III_MAX = 6'h27;
    localparam logic [OP_W-1:0]  OP_FMT_IV_A    = 6'h2A;
    localparam logic [OP_W-1:0]  OP_FMT_IV_B    = 6'h2B;
    localparam logic [OP_W-1:0]  OP_FMT_V_A     = 6'h28;
    localparam logic [OP_W-1:0]  OP_FMT_V_B     = 6'h29;
    localparam logic [OP_W-1:0]  OP_FMT_V_LO    = 6'h2C;
    localparam logic [OP_W-1:0]  OP_FMT_V_HI    = 6'h2F;
    localparam logic [OP_W-1:0]  OP_FMT_VI_MIN  = 6'h30;
    localparam logic [OP_W-1:0]  SUB_DEF_0      = 6'h00;
    localparam logic [OP_W-1:0]  SUB_DEF_LO     = 6'h02;
    localparam logic [OP_W-1:0]  SUB_DEF_HI     = 6'h0C;
    localparam logic [LEN_W-1:0] LEN_SHORT      = 3'd2;
    localparam logic [LEN_W-1:0] LEN_LONG       = 3'd4;
    localparam logic [LEN_W-1:0] LEN_NONE       = 3'd0;

endpackage

// File: hdl/instruction_format_decoder_core.sv
// instruction format decoder: offset check, format classification and field extraction
//
//  channel | direction | handshake                     | payload
//  in      | to core   | i_in_valid / o_in_stall       | offset, first and second halfword
//  out     | from core | o_out_valid / i_out_stall     | fetch_ok .. defined_op
//  cfg     | to core   | i_cfg_valid / o_cfg_ready     | image size in bytes
//
//  one word per cycle unless the result side stalls; path: input register, decode, result register
//  a single combinational decode stage lies between the two registers
//  synchronous active-low reset empties both stages and clears the image size
//  a stalled result holds the result register; one more word still enters the input register
//  cfg writes are always taken, o_cfg_ready is held high
module instruction_format_decoder_core
    import ifd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ROM_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OFFSET_W-1:0]        i_fetch_offset,
    input  logic [HALF_W-1:0]          i_first_half,
    input  logic [HALF_W-1:0]          i_second_half,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_fetch_ok,
    output logic [2:0]                 o_format_kind,
    output logic [LEN_W-1:0]           o_length_bytes,
    output logic [OP_W-1:0]            o_major_opcode,
    output logic [REG_W-1:0]           o_first_reg,
    output logic [REG_W-1:0]           o_second_reg,
    output logic [COND_W-1:0]          o_branch_cond,
    output logic [OP_W-1:0]            o_sub_opcode,
    output logic signed [IMM_W-1:0]    o_immediate,
    output logic                       o_defined_op
);

    logic [ROM_W-1:0]    r_image_bytes;
    logic                r_s1_vld;
    logic [OFFSET_W-1:0] r_off;
    logic [HALF_W-1:0]   r_hw1;
    logic [HALF_W-1:0]   r_hw2;
    logic                adv;

    logic                n_ok;
    t_format             n_fmt;
    logic [LEN_W-1:0]    n_len;
    logic [OP_W-1:0]     n_op;
    logic [REG_W-1:0]    n_reg1;
    logic [REG_W-1:0]    n_reg2;
    logic [COND_W-1:0]   n_cond;
    logic [OP_W-1:0]     n_sub;
    logic [IMM_W-1:0]    n_imm;
    logic                n_def;

    logic                r_out_vld;
    logic                r_ok;
    logic [2:0]          r_fmt;
    logic [LEN_W-1:0]    r_len;
    logic [OP_W-1:0]     r_op;
    logic [REG_W-1:0]    r_reg1;
    logic [REG_W-1:0]    r_reg2;
    logic [COND_W-1:0]   r_cond;
    logic [OP_W-1:0]     r_sub;
    logic [IMM_W-1:0]    r_imm;
    logic                r_def;

    assign o_cfg_ready = 1'b1;
    assign adv         = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_s1_vld && !adv;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes <= '0;
        end else if (i_cfg_valid) begin
            r_image_bytes <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_off <= i_fetch_offset;
            r_hw1 <= i_first_half;
            r_hw2 <= i_second_half;
        end
    end

    // decode
    always_comb begin
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] len;
        logic [ROM_W:0]   end_pos;
        t_format          fmt;
        logic [COND_W-1:0] cond;
        logic [OP_W-1:0]  sub;
        logic [IMM_W-1:0] imm;
        logic             def;

        op      = r_hw1[15:10];
        len     = (op >= OP_LONG_MIN) ? LEN_LONG : LEN_SHORT;
        end_pos = {2'b00, r_off} + {{(ROM_W+1-LEN_W){1'b0}}, len};
        cond    = '0;
        sub     = '0;
        imm     = '0;

        case (op) inside
            [OP_FMT_I_MIN:OP_FMT_I_MAX]: begin
                fmt = FMT_I;
            end
            [OP_FMT_II_MIN:OP_FMT_II_MAX]: begin
                fmt = FMT_II;
                imm = {{(IMM_W-5){r_hw1[4]}}, r_hw1[4:0]};
            end
            [OP_FMT_III_MIN:OP_FMT_III_MAX]: begin
                fmt  = FMT_III;
                cond = r_hw1[12:9];
                imm  = {{(IMM_W-9){r_hw1[8]}}, r_hw1[8:0]};
            end
            OP_FMT_IV_A, OP_FMT_IV_B: begin
                fmt = FMT_IV;
                imm = {r_hw1[9:0], r_hw2};
            end
            OP_FMT_V_A, OP_FMT_V_B, [OP_FMT_V_LO:OP_FMT_V_HI]: begin
                fmt = FMT_V;
                imm = {{(IMM_W-HALF_W){r_hw2[15]}}, r_hw2};
            end
            OP_EXT: begin
                fmt = FMT_VII;
                sub = r_hw2[15:10];
            end
            default: begin
                fmt = FMT_VI;
                imm = {{(IMM_W-HALF_W){r_hw2[15]}}, r_hw2};
            end
        endcase

        if (op == OP_UNDEF_A || op == OP_UNDEF_B || op == OP_UNDEF_C) begin
            def = 1'b0;
        end else if (op == OP_EXT) begin
            def = (sub == SUB_DEF_0) || (sub >= SUB_DEF_LO && sub <= SUB_DEF_HI);
        end else begin
            def = 1'b1;
        end

        n_ok = (end_pos <= {1'b0, r_image_bytes});
        if (n_ok) begin
            n_fmt  = fmt;
            n_len  = len;
            n_op   = op;
            n_reg1 = r_hw1[4:0];
            n_reg2 = r_hw1[9:5];
            n_cond = cond;
            n_sub  = sub;
            n_imm  = imm;
            n_def  = def;
        end else begin
            n_fmt  = FMT_I;
            n_len  = LEN_NONE;
            n_op   = '0;
            n_reg1 = '0;
            n_reg2 = '0;
            n_cond = '0;
            n_sub  = '0;
            n_imm  = '0;
            n_def  = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_vld) begin
            r_ok   <= n_ok;
            r_fmt  <= n_fmt;
            r_len  <= n_len;
            r_op   <= n_op;
            r_reg1 <= n_reg1;
            r_reg2 <= n_reg2;
            r_cond <= n_cond;
            r_sub  <= n_sub;
            r_imm  <= n_imm;
            r_def  <= n_def;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_fetch_ok     = r_ok;
    assign o_format_kind  = r_fmt;
    assign o_length_bytes = r_len;
    assign o_major_opcode = r_op;
    assign o_first_reg    = r_reg1;
    assign o_second_reg   = r_reg2;
    assign o_branch_cond  = r_cond;
    assign o_sub_opcode   = r_sub;
    assign o_immediate    = $signed(r_imm);
    assign o_defined_op   = r_def;

    `include "instruction_format_decoder_core_defines.svh"

    `IFD_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, r_out_vld && !r_ok, r_len == LEN_NONE && r_imm == '0 && r_fmt == FMT_I && r_def == 1'b0, "failed fetch with nonzero fields")
    `IFD_ASSERT_SAME(a_len_op, i_clk, i_rst_n, r_out_vld && r_ok, (r_len == LEN_LONG) == (r_op >= OP_LONG_MIN), "length does not match opcode")
    `IFD_ASSERT_SAME(a_sub_fmt, i_clk, i_rst_n, r_out_vld && r_fmt != FMT_VII, r_sub == '0, "subopcode outside extended format")
    `IFD_ASSERT_NEXT(a_in_taken, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_s1_vld, "accepted word lost at input register")

endmodule

// File: bench/decode_checker.sv
`timescale 1ns / 1ps
// decode checker: watches the three channels, predicts each decode and compares the results
module decode_checker
    import ifd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [ROM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [OFFSET_W-1:0]  i_fetch_offset,
    input  logic [HALF_W-1:0]    i_first_half,
    input  logic [HALF_W-1:0]    i_second_half,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_fetch_ok,
    input  logic [2:0]           i_format_kind,
    input  logic [LEN_W-1:0]     i_length_bytes,
    input  logic [OP_W-1:0]      i_major_opcode,
    input  logic [REG_W-1:0]     i_first_reg,
    input  logic [REG_W-1:0]     i_second_reg,
    input  logic [COND_W-1:0]    i_branch_cond,
    input  logic [OP_W-1:0]      i_sub_opcode,
    input  logic [IMM_W-1:0]     i_immediate,
    input  logic                 i_defined_op,
    output int                   o_mismatches,
    output int                   o_pending
);

    typedef struct packed {
        logic               ok;
        t_format            fmt;
        logic [LEN_W-1:0]   len;
        logic [OP_W-1:0]    op;
        logic [REG_W-1:0]   ra;
        logic [REG_W-1:0]   rb;
        logic [COND_W-1:0]  cond;
        logic [OP_W-1:0]    sub;
        logic [IMM_W-1:0]   imm;
        logic               defd;
    } t_decode;

    t_decode           expected_decodes[$];
    logic [ROM_W-1:0]  rom_bytes = '0;
    int                mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic t_decode decode_fetch(input logic [OFFSET_W-1:0] offset,
                                             input logic [HALF_W-1:0] first,
                                             input logic [HALF_W-1:0] second,
                                             input logic [ROM_W-1:0] rom);
        t_decode          d;
        logic [OP_W-1:0]  op;
        logic [ROM_W:0]   reach;
        d = '0;
        op = first[15:10];
        d.len = (op >= OP_LONG_MIN) ? LEN_LONG : LEN_SHORT;
        reach = {2'b00, offset} + {{(ROM_W+1-LEN_W){1'b0}}, d.len};
        if (reach > {1'b0, rom}) begin
            return '0;
        end
        d.ok = 1'b1;
        d.op = op;
        d.ra = first[4:0];
        d.rb = first[9:5];
        if (op == OP_EXT) begin
            d.fmt = FMT_VII;
            d.sub = second[15:10];
        end else if (op == OP_FMT_IV_A || op == OP_FMT_IV_B) begin
            d.fmt = FMT_IV;
            d.imm = {first[9:0], second};
        end else if (op >= OP_FMT_VI_MIN) begin
            d.fmt = FMT_VI;
            d.imm = IMM_W'($signed(second));
        end else if (op >= OP_LONG_MIN) begin
            d.fmt = FMT_V;
            d.imm = IMM_W'($signed(second));
        end else if (op >= OP_FMT_III_MIN) begin
            d.fmt  = FMT_III;
            d.cond = first[12:9];
            d.imm  = IMM_W'($signed(first[8:0]));
        end else if (op >= OP_FMT_II_MIN) begin
            d.fmt = FMT_II;
            d.imm = IMM_W'($signed(first[4:0]));
        end else begin
            d.fmt = FMT_I;
        end
        d.defd = !(op == OP_UNDEF_A || op == OP_UNDEF_B || op == OP_UNDEF_C)
                 && (op != OP_EXT || d.sub == SUB_DEF_0
                     || (d.sub >= SUB_DEF_LO && d.sub <= SUB_DEF_HI));
        return d;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_decode want;
        t_decode got;
        if (!i_rst_n) begin
            expected_decodes.delete();
            rom_bytes <= '0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_decodes.size() == 0) begin
                    $display("%0t: decode word with no expectation waiting", $time);
                    mismatches++;
                end else begin
                    want = expected_decodes.pop_front();
                    got  = {i_fetch_ok, t_format'(i_format_kind), i_length_bytes,
                            i_major_opcode, i_first_reg, i_second_reg, i_branch_cond,
                            i_sub_opcode, i_immediate, i_defined_op};
                    check_field("fetch_ok", want.ok, got.ok);
                    check_field("format_kind", int'(want.fmt), int'(got.fmt));
                    check_field("length_bytes", want.len, got.len);
                    check_field("major_opcode", want.op, got.op);
                    check_field("first_reg", want.ra, got.ra);
                    check_field("second_reg", want.rb, got.rb);
                    check_field("branch_cond", want.cond, got.cond);
                    check_field("sub_opcode", want.sub, got.sub);
                    check_field("immediate", int'($signed(want.imm)), int'($signed(got.imm)));
                    check_field("defined_op", want.defd, got.defd);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                rom_bytes <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_decodes.push_back(decode_fetch(i_fetch_offset, i_first_half,
                                                        i_second_half, rom_bytes));
            end
            o_pending <= expected_decodes.size();
        end
    end

endmodule

// File: bench/tb_instruction_format_decoder_core.sv
`timescale 1ns / 1ps
// testbench top for the instruction format decoder: stimulus, back-pressure and verdict
module tb_instruction_format_decoder_core;
    import ifd_pkg::*;

    localparam int               QUIET_LIMIT     = 2000;
    localparam int               IDLE_PCT        = 37;
    localparam int               HOLD_OFF_AT     = 300;
    localparam int               HOLD_OFF_CYCLES = 150;
    localparam int               CALM_FROM       = 450;
    localparam int               CALM_TO         = 750;
    localparam logic [ROM_W-1:0] ROM_FULL        = 25'h1000000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [ROM_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [OFFSET_W-1:0]     i_fetch_offset;
    logic [HALF_W-1:0]       i_first_half;
    logic [HALF_W-1:0]       i_second_half;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_fetch_ok;
    logic [2:0]              o_format_kind;
    logic [LEN_W-1:0]        o_length_bytes;
    logic [OP_W-1:0]         o_major_opcode;
    logic [REG_W-1:0]        o_first_reg;
    logic [REG_W-1:0]        o_second_reg;
    logic [COND_W-1:0]       o_branch_cond;
    logic [OP_W-1:0]         o_sub_opcode;
    logic signed [IMM_W-1:0] o_immediate;
    logic                    o_defined_op;

    int                      mismatches;
    int                      decodes_pending;
    int                      quiet_cycles = 0;
    int                      items_sent = 0;
    logic [ROM_W-1:0]        cur_rom = '0;

    instruction_format_decoder_core uut (.*);

    decode_checker decode_watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_fetch_offset (i_fetch_offset),
        .i_first_half   (i_first_half),
        .i_second_half  (i_second_half),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_fetch_ok     (o_fetch_ok),
        .i_format_kind  (o_format_kind),
        .i_length_bytes (o_length_bytes),
        .i_major_opcode (o_major_opcode),
        .i_first_reg    (o_first_reg),
        .i_second_reg   (o_second_reg),
        .i_branch_cond  (o_branch_cond),
        .i_sub_opcode   (o_sub_opcode),
        .i_immediate    (o_immediate),
        .i_defined_op   (o_defined_op),
        .o_mismatches   (mismatches),
        .o_pending      (decodes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, one long hold-off, one calm stretch
    initial begin : result_sink
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                taken++;
            end
            if (!held && taken >= HOLD_OFF_AT) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (taken >= CALM_FROM + 50 && taken < CALM_TO + 50) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_fetch(input logic [OFFSET_W-1:0] offset,
                              input logic [HALF_W-1:0] first,
                              input logic [HALF_W-1:0] second);
        while (!(items_sent >= CALM_FROM && items_sent < CALM_TO)
               && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid     <= 1'b0;
            i_fetch_offset <= OFFSET_W'($urandom);
            i_first_half   <= HALF_W'($urandom);
            i_second_half  <= HALF_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_fetch_offset <= offset;
        i_first_half   <= first;
        i_second_half  <= second;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic random_fetch();
        logic [OFFSET_W-1:0] offset;
        logic [HALF_W-1:0]   first;
        logic [HALF_W-1:0]   second;
        int                  near;
        case ($urandom_range(3))
            0: begin
                offset = OFFSET_W'($urandom);
            end
            1: begin
                near = int'(cur_rom) - int'($urandom_range(6));
                if (near < 0) begin
                    near = 0;
                end
                if (near > 32'h00FF_FFFF) begin
                    near = 32'h00FF_FFFF;
                end
                offset = OFFSET_W'(near);
            end
            2: begin
                offset = OFFSET_W'($urandom_range(15));
            end
            default: begin
                offset = (cur_rom == 0) ? '0 : OFFSET_W'($urandom_range(cur_rom - 1));
            end
        endcase
        first  = HALF_W'($urandom);
        second = HALF_W'($urandom);
        // dwell on the extended opcode around its defined subopcodes
        if ($urandom_range(7) == 0) begin
            first[15:10]  = OP_EXT;
            second[15:10] = OP_W'($urandom_range(15));
        end
        send_fetch(offset, first, second);
    endtask

    task automatic run_random(input int count);
        repeat (count) random_fetch();
    endtask

    task automatic drain_and_configure(input logic [ROM_W-1:0] rom);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decodes_pending != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rom;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_rom = rom;
    endtask

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_fetch_offset <= '0;
        i_first_half   <= '0;
        i_second_half  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty image after reset: every fetch fails
        run_random(60);

        drain_and_configure(ROM_FULL);
        send_fetch(24'h000000, 16'h0000, 16'h0000);
        send_fetch(24'h000001, 16'h401F, 16'hFFFF);
        send_fetch(24'h000002, {OP_UNDEF_A, 10'h010}, 16'h0000);
        send_fetch(24'h000003, 16'h7FFF, 16'h0000);
        send_fetch(24'h000004, 16'h8100, 16'h0000);
        send_fetch(24'h000005, 16'h9FFF, 16'h0000);
        send_fetch(24'h000006, {OP_LONG_MIN, 10'h000}, 16'h8000);
        send_fetch(24'h000008, 16'hA7FF, 16'h7FFF);
        send_fetch(24'h00000A, 16'hABFF, 16'hFFFF);
        send_fetch(24'h00000C, 16'hAE00, 16'h0000);
        send_fetch(24'h00000E, 16'hBFFF, 16'h8000);
        send_fetch(24'h000010, 16'hC000, 16'h8001);
        send_fetch(24'h000014, {OP_UNDEF_B, 10'h155}, 16'h0001);
        send_fetch(24'h000018, {OP_UNDEF_C, 10'h2AA}, 16'hFFFE);
        send_fetch(24'h00001C, 16'hF7FF, 16'h7FFF);
        send_fetch(24'h000020, {OP_EXT, 10'h000}, {SUB_DEF_0, 10'h3FF});
        send_fetch(24'h000024, {OP_EXT, 10'h01F}, 16'h0400);
        send_fetch(24'h000028, {OP_EXT, 10'h0E0}, {SUB_DEF_LO, 10'h000});
        send_fetch(24'h00002C, {OP_EXT, 10'h3FF}, {SUB_DEF_HI, 10'h155});
        send_fetch(24'h000030, {OP_EXT, 10'h000}, 16'h3400);
        send_fetch(24'h000034, {OP_EXT, 10'h000}, 16'hFFFF);
        // image end: exact fit, long form past it, short fit, short past it
        send_fetch(24'hFFFFFC, 16'hFFFF, 16'hFFFF);
        send_fetch(24'hFFFFFE, 16'hFFFF, 16'h0000);
        send_fetch(24'hFFFFFE, 16'h0FFF, 16'hFFFF);
        send_fetch(24'hFFFFFF, 16'h0000, 16'h0000);
        run_random(400);

        drain_and_configure(25'd4);
        run_random(100);
        drain_and_configure(25'd2);
        run_random(80);
        drain_and_configure(25'd3);
        run_random(80);
        drain_and_configure(25'h0001000);
        run_random(250);
        drain_and_configure(ROM_W'($urandom_range(ROM_FULL, 5)));
        run_random(250);
        drain_and_configure(25'h0FFFFFF);
        run_random(120);
        drain_and_configure(25'd0);
        run_random(40);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decodes_pending != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ifd_pkg.sv
hdl/instruction_format_decoder_core.sv
bench/decode_checker.sv
bench/tb_instruction_format_decoder_core.sv
